/* rtl/idfa_pkg.sv */
// shared types and constants for the id free list allocator
package idfa_pkg;

    localparam int MAX_IDS = 64;
    localparam int IDX_W   = $clog2(MAX_IDS);
    localparam int SLOT_W  = $clog2(MAX_IDS + 1);
    localparam int LIMIT_W = 7;
    localparam int ID_W    = 8;
    localparam int STAT_W  = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_IDS);

    // request codes
    typedef enum logic
    {
        ACT_GET = 1'b0,
        ACT_PUT = 1'b1
    } action_t;

    // result status codes
    typedef enum logic [STAT_W-1:0]
    {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_DUP   = 2'd3
    } status_t;

    // control broadcast to every cell of the row
    typedef struct packed
    {
        logic               refill;
        logic [SLOT_W-1:0]  lim;
        logic               pop;
        logic [SLOT_W-1:0]  grant_id;
        logic               push;
        logic [SLOT_W-1:0]  push_id;
        logic [SLOT_W-1:0]  count;
    } cell_ctl_t;

endpackage

/* rtl/idfa_req_if.sv */
// request channel: action and id with valid/ready
interface idfa_req_if
    import idfa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [ID_W-1:0]   id;

    modport source (output valid, output action, output id, input ready);
    modport sink   (input valid, input action, input id, output ready);
endinterface

/* rtl/idfa_rsp_if.sv */
// result channel: result id and status with valid/ready
interface idfa_rsp_if
    import idfa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     result_id;
    logic [STAT_W-1:0]   status;

    modport source (output valid, output result_id, output status, input ready);
    modport sink   (input valid, input result_id, input status, output ready);
endinterface

/* rtl/idfa_cell.sv */
// one cell: a free queue slot plus the free flag of the id it owns
module idfa_cell
    import idfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  idx,
    input  cell_ctl_t         ctl,
    input  logic [SLOT_W-1:0] slot_in,
    output logic [SLOT_W-1:0] slot_out,
    output logic              free_hit
);

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              free_reg;
    logic              free_next;
    logic [SLOT_W-1:0] own_id;
    logic [SLOT_W-1:0] pos;

    assign own_id = SLOT_W'(idx) + SLOT_W'(1);
    assign pos    = SLOT_W'(idx);

    // queue slot: refill, shift toward head on pop, write at tail on push
    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.refill)
        begin
            slot_next = own_id;
        end
        else if (ctl.pop)
        begin
            slot_next = slot_in;
        end
        else if (ctl.push && (ctl.count == pos))
        begin
            slot_next = ctl.push_id;
        end
    end

    // free flag of the id this cell owns
    always_comb
    begin
        free_next = free_reg;
        if (ctl.refill)
        begin
            free_next = (own_id <= ctl.lim);
        end
        else if (ctl.pop && (ctl.grant_id == own_id))
        begin
            free_next = 1'b0;
        end
        else if (ctl.push && (ctl.push_id == own_id))
        begin
            free_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= own_id;
            free_reg <= 1'b1;
        end
        else
        begin
            slot_reg <= slot_next;
            free_reg <= free_next;
        end
    end

    assign slot_out = slot_reg;
    assign free_hit = free_reg && (ctl.push_id == own_id);

endmodule

/* rtl/id_free_list_allocator.sv */
// id free list allocator: fifo of free ids kept in a shifting row of cells
//
// req channel: action (get = 0, put = 1) and id, valid/ready transfer.
// rsp channel: result_id and status, one result per request, in order.
// cfg_we/cfg_wdata write the id limit (saturated to MAX_IDS) and refill the
// free queue with 1..limit in ascending order; write only while idle.
// Each request is handled in the cycle of its transfer: the whole cell row
// shifts or writes at once, so the result is valid on the next cycle.
// Throughput is one request per cycle while results are taken; the output
// register holds a result until its transfer and req.ready is low while a
// held result is not being taken.
// After reset the limit is 64 and all ids 1..64 are free, in order.
// Status: 0 ok, 1 pool empty, 2 id out of range, 3 id already free.
module id_free_list_allocator
    import idfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    idfa_req_if.sink           req,
    idfa_rsp_if.source         rsp
);

    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;
    logic [SLOT_W-1:0]  count_reg;
    logic [SLOT_W-1:0]  count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [ID_W-1:0]    result_id_reg;
    logic [ID_W-1:0]    result_id_next;
    status_t            status_reg;
    status_t            status_next;

    logic               accept;
    logic [LIMIT_W-1:0] cfg_sat;
    logic               in_range;
    logic               dup;
    cell_ctl_t          ctl;

    logic [SLOT_W-1:0]  slots [MAX_IDS];
    logic [MAX_IDS-1:0] hits;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // saturate written limit
    assign cfg_sat = (cfg_wdata > LIMIT_RESET) ? LIMIT_RESET : cfg_wdata;

    // return checks
    assign in_range = (req.id != '0) && (req.id <= ID_W'(limit_reg));
    assign dup      = |hits;

    // request decode and cell control
    always_comb
    begin
        ctl            = '0;
        ctl.lim        = SLOT_W'(cfg_sat);
        ctl.refill     = cfg_we;
        ctl.grant_id   = slots[0];
        ctl.push_id    = SLOT_W'(req.id);
        ctl.count      = count_reg;
        limit_next     = limit_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        result_id_next = result_id_reg;
        status_next    = status_reg;

        if (cfg_we)
        begin
            limit_next = cfg_sat;
            count_next = SLOT_W'(cfg_sat);
        end
        else if (accept)
        begin
            out_valid_next = 1'b1;
            if (action_t'(req.action) == ACT_GET)
            begin
                if (count_reg == '0)
                begin
                    status_next    = ST_EMPTY;
                    result_id_next = '0;
                end
                else
                begin
                    ctl.pop        = 1'b1;
                    count_next     = count_reg - SLOT_W'(1);
                    status_next    = ST_OK;
                    result_id_next = ID_W'(slots[0]);
                end
            end
            else
            begin
                if (!in_range)
                begin
                    status_next    = ST_RANGE;
                    result_id_next = '0;
                end
                else if (dup)
                begin
                    status_next    = ST_DUP;
                    result_id_next = req.id;
                end
                else
                begin
                    ctl.push       = 1'b1;
                    count_next     = count_reg + SLOT_W'(1);
                    status_next    = ST_OK;
                    result_id_next = req.id;
                end
            end
        end
    end

    // row of cells, each shifting its slot toward the head on a pop
    for (genvar i = 0; i < MAX_IDS; i++)
    begin : g_cell
        logic [SLOT_W-1:0] nb;
        if (i == MAX_IDS - 1)
        begin : g_last
            assign nb = '0;
        end
        else
        begin : g_mid
            assign nb = slots[i+1];
        end
        idfa_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (IDX_W'(i)),
            .ctl      (ctl),
            .slot_in  (nb),
            .slot_out (slots[i]),
            .free_hit (hits[i])
        );
    end

    // control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            count_reg     <= SLOT_W'(MAX_IDS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_id_reg <= result_id_next;
        status_reg    <= status_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.result_id = result_id_reg;
    assign rsp.status    = status_reg;

endmodule

/* verif/tb_id_free_list_allocator.sv */
// testbench for the id free list allocator: directed and random get/put traffic with a pool model
module tb_id_free_list_allocator;
    import idfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        logic [ID_W-1:0] result_id;
        status_t         status;
    } alloc_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;

    idfa_req_if req_ch ();
    idfa_rsp_if rsp_ch ();

    id_free_list_allocator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // pool model: limit, free queue in hand-out order, per-id free flags
    int                 pool_limit;
    logic [ID_W-1:0]    free_ids[$];
    bit                 id_free[0:MAX_IDS];
    alloc_result_t      pending_results[$];

    // traffic shaping shared with the result sink
    bit src_idle_en;
    bit sink_idle_en;
    int hold_cycles;

    int n_errors;
    int n_checked;
    int n_limit_writes;
    int status_seen[4];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #400_000;
        $display("%0t: run limit reached", $time);
        $display("FAIL");
        $finish;
    end

    // refill the pool model after a limit write
    function automatic void refill_pool(input logic [LIMIT_W-1:0] value);
        int lim;
        lim = int'(value);
        if (lim > MAX_IDS)
            lim = MAX_IDS;
        pool_limit = lim;
        free_ids.delete();
        foreach (id_free[i])
            id_free[i] = 1'b0;
        for (int i = 1; i <= lim; i++)
        begin
            free_ids.push_back(ID_W'(i));
            id_free[i] = 1'b1;
        end
    endfunction

    // expected result of one get or put, updating the pool model
    function automatic alloc_result_t predict_alloc(input action_t act,
                                                     input logic [ID_W-1:0] id_val);
        alloc_result_t r;
        r.result_id = '0;
        r.status    = ST_OK;
        if (act == ACT_GET)
        begin
            if (free_ids.size() == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.result_id = free_ids.pop_front();
                id_free[r.result_id] = 1'b0;
            end
        end
        else if (id_val < 1 || int'(id_val) > pool_limit)
            r.status = ST_RANGE;
        else if (id_free[id_val])
        begin
            r.status    = ST_DUP;
            r.result_id = id_val;
        end
        else
        begin
            free_ids.push_back(id_val);
            id_free[id_val] = 1'b1;
            r.result_id = id_val;
        end
        return r;
    endfunction

    // predict on each request transfer, check each result transfer
    always @(posedge clk)
    begin : monitor
        alloc_result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual id %0d status %0d",
                             $time, rsp_ch.result_id, rsp_ch.status);
                    n_errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    n_checked++;
                    status_seen[want.status]++;
                    if (rsp_ch.result_id !== want.result_id)
                    begin
                        $display("%0t: result_id mismatch: expected %0d, actual %0d",
                                 $time, want.result_id, rsp_ch.result_id);
                        n_errors++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, rsp_ch.status);
                        n_errors++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
                pending_results.push_back(predict_alloc(action_t'(req_ch.action), req_ch.id));
        end
    end

    // result sink: random stall bursts, or one long hold-off on request
    initial
    begin : result_sink
        int gap;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                rsp_ch.ready <= 1'b1;
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 7);
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // offer one request and wait for its transfer
    task automatic send_item(input action_t act, input logic [ID_W-1:0] id_val);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.id     <= id_val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // stop offering and wait until every result has come back
    task automatic wait_drained();
        int spins;
        req_ch.valid <= 1'b0;
        spins = 0;
        @(posedge clk);
        while (pending_results.size() != 0 && spins < 5000)
        begin
            @(posedge clk);
            spins++;
        end
        if (pending_results.size() != 0)
        begin
            $display("%0t: results missing: expected %0d more, actual 0",
                     $time, pending_results.size());
            n_errors++;
            pending_results.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    // write the id limit while idle
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        refill_pool(value);
        n_limit_writes++;
        @(posedge clk);
    endtask

    // one random request: mostly gets and returns of ids in use, some noise
    task automatic send_random_item(input int get_pct);
        int busy[$];
        int r;
        logic [ID_W-1:0] pick;
        r = $urandom_range(0, 99);
        if (r < get_pct)
            send_item(ACT_GET, ID_W'($urandom));
        else
        begin
            for (int i = 1; i <= pool_limit; i++)
                if (!id_free[i])
                    busy.push_back(i);
            r = $urandom_range(0, 99);
            if (busy.size() != 0 && r < 75)
                pick = ID_W'(busy[$urandom_range(0, busy.size() - 1)]);
            else if (r < 88 && pool_limit != 0)
                pick = ID_W'($urandom_range(1, pool_limit));
            else
                pick = ID_W'($urandom);
            send_item(ACT_PUT, pick);
        end
    endtask

    // reset pool: ascending grants, range edges, duplicate and good returns
    task automatic test_reset_pool();
        send_item(ACT_GET, 8'hFF);
        send_item(ACT_GET, 8'h00);
        send_item(ACT_GET, 8'h00);
        send_item(ACT_PUT, 8'd0);
        send_item(ACT_PUT, 8'd65);
        send_item(ACT_PUT, 8'd255);
        send_item(ACT_PUT, 8'd2);
        send_item(ACT_PUT, 8'd2);
        send_item(ACT_PUT, 8'd64);
        send_item(ACT_GET, 8'h00);
        wait_drained();
    endtask

    // limit of zero, saturating limit, single-id pool
    task automatic test_limit_extremes();
        write_limit(7'd0);
        send_item(ACT_GET, 8'h00);
        send_item(ACT_PUT, 8'd1);
        send_item(ACT_PUT, 8'd0);
        wait_drained();
        write_limit(7'd127);
        send_item(ACT_GET, 8'h00);
        send_item(ACT_PUT, 8'd64);
        send_item(ACT_PUT, 8'd65);
        wait_drained();
        write_limit(7'd1);
        send_item(ACT_GET, 8'h00);
        send_item(ACT_GET, 8'h00);
        send_item(ACT_PUT, 8'd1);
        send_item(ACT_PUT, 8'd1);
        send_item(ACT_PUT, 8'd2);
        wait_drained();
    endtask

    // random phases, each with its own limit and get/put balance
    task automatic test_random_phases();
        logic [LIMIT_W-1:0] lim;
        int get_pct;
        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 5))
                0: lim = 7'd0;
                1: lim = 7'd1;
                2: lim = 7'd64;
                3: lim = 7'd127;
                4: lim = LIMIT_W'($urandom_range(2, 63));
                default: lim = LIMIT_W'($urandom_range(65, 126));
            endcase
            if (phase == 0)
                lim = LIMIT_W'($urandom_range(2, 63));
            get_pct = $urandom_range(30, 70);
            write_limit(lim);
            for (int n = 0; n < 110; n++)
                send_random_item(get_pct);
            wait_drained();
        end
    endtask

    // long result hold-off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        write_limit(7'd8);
        src_idle_en = 1'b0;
        hold_cycles = 80;
        for (int n = 0; n < 20; n++)
            send_random_item(50);
        wait_drained();
    endtask

    // back-to-back transfers with no idling on either side
    task automatic test_full_rate();
        write_limit(7'd64);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        for (int n = 0; n < 120; n++)
            send_random_item(55);
        wait_drained();
    endtask

    // main sequence
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_GET;
        req_ch.id     = '0;
        src_idle_en   = 1'b1;
        sink_idle_en  = 1'b1;
        hold_cycles   = 0;
        refill_pool(LIMIT_RESET);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_pool();
        test_limit_extremes();
        src_idle_en = 1'b1;
        test_random_phases();
        test_backpressure();
        test_full_rate();

        $display("checked %0d results: ok %0d, empty %0d, out of range %0d, already free %0d",
                 n_checked, status_seen[ST_OK], status_seen[ST_EMPTY],
                 status_seen[ST_RANGE], status_seen[ST_DUP]);
        $display("limit written %0d times, zero, one, full and saturating values among them",
                 n_limit_writes);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* id_free_list_allocator.f */
rtl/idfa_pkg.sv
rtl/idfa_req_if.sv
rtl/idfa_rsp_if.sv
rtl/idfa_cell.sv
rtl/id_free_list_allocator.sv
verif/tb_id_free_list_allocator.sv
